/* design/assert_macros.svh */
// Assertion macros used by the cooked line input buffer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge outside reset.
`define AST_CHECK(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define AST_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/clib_pkg.sv */
// Shared constants, types and ring helpers for the cooked line input buffer.
package clib_pkg;

   localparam int DEPTH = 256;
   localparam int PTR_W = $clog2(DEPTH);

   localparam logic [7:0] CH_RET  = 8'd13;
   localparam logic [7:0] CH_NL   = 8'd10;
   localparam logic [7:0] CH_BS   = 8'd8;
   localparam logic [7:0] CH_BEL  = 8'd7;
   localparam logic [7:0] KEY_MAX = 8'd127;

   typedef enum logic [1:0] {
      OP_KEY  = 2'd0,
      OP_RAW  = 2'd1,
      OP_TAKE = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_FULL    = 3'd1,
      STAT_REFUSED = 3'd2,
      STAT_BLOCK   = 3'd3,
      STAT_EMPTY   = 3'd4
   } status_type;

   typedef struct packed {
      logic             en;
      logic [PTR_W-1:0] addr;
      logic [7:0]       data;
   } wr_req_type;

   function automatic logic [PTR_W-1:0] next_pos(input logic [PTR_W-1:0] p);
      if (p == PTR_W'(DEPTH - 1)) return '0;
      else return p + PTR_W'(1);
   endfunction

   function automatic logic [PTR_W-1:0] prev_pos(input logic [PTR_W-1:0] p);
      if (p == '0) return PTR_W'(DEPTH - 1);
      else return p - PTR_W'(1);
   endfunction

   function automatic logic [7:0] sat8(input logic [PTR_W-1:0] c);
      logic [PTR_W+7:0] wide;
      wide = {8'b0, c};
      if (wide > (PTR_W + 8)'(255)) return 8'hFF;
      else return wide[7:0];
   endfunction

endpackage

/* design/cooked_line_input_buffer.sv */
// Cooked line input buffer: a keyboard ring buffer of DEPTH-1 characters with a
// terminal line discipline. Each request is a key put (optionally ctrl-masked,
// backspace erases the last character in cooked mode), a raw put, a take or a
// no-op; every request yields exactly one response carrying the delivered
// character, a status code and the number of line ends still stored. Characters
// live in a single-port-read synchronous RAM: an accepted request reads the
// entry it needs (the slot below the write pointer, or the read slot) and
// then, in the execute state, the block decides, writes back and loads the
// response register. It takes no new request before the current one leaves
// the execute state; the response register lets a new request in while the
// previous response waits, and the block only holds in its execute state if
// that earlier response has not been taken. The RAM needs no clearing after
// reset: only written entries are ever used. csr_wr_en/csr_wr_data set cooked
// mode (reset value 1) and are meant to be used only while the block is idle.
`include "assert_macros.svh"

module cooked_line_input_buffer (
   input  logic       clock,
   input  logic       reset,

   input  logic       csr_wr_en,
   input  logic       csr_wr_data,

   input  logic       req_valid,
   output logic       req_ready,
   input  logic [1:0] req_op,
   input  logic [7:0] req_char_in,
   input  logic       req_ctrl_held,

   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_char_out,
   output logic       rsp_delivered,
   output logic [2:0] rsp_status,
   output logic       rsp_line_end,
   output logic [7:0] rsp_lines_pending
);

   localparam int PW = clib_pkg::PTR_W;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type              state_ff, state_in;
   logic                   cooked_ff;
   logic [PW-1:0]          wp_ff, wp_in;
   logic [PW-1:0]          rp_ff, rp_in;
   logic [PW-1:0]          lc_ff, lc_in;

   // request captured for the execute cycle
   clib_pkg::op_type       op_ff;
   logic [7:0]             char_ff;
   logic                   ctrl_ff;

   // response register
   logic                   rsp_valid_ff;
   logic [7:0]             rsp_char_ff, rsp_char_in;
   logic                   rsp_dlv_ff, rsp_dlv_in;
   clib_pkg::status_type   rsp_stat_ff, rsp_stat_in;
   logic                   rsp_lend_ff, rsp_lend_in;
   logic [7:0]             rsp_lines_ff;

   // RAM interface
   clib_pkg::wr_req_type   wr_req;
   logic                   rd_en;
   logic [PW-1:0]          rd_addr;
   logic [7:0]             rd_data;

   logic                   accept;
   logic                   finish;
   logic                   empty;
   logic                   full;
   logic                   do_put;
   logic [7:0]             put_char;
   logic [PW-1:0]          occupancy;

   clib_store u_store (
      .clock   (clock),
      .wr_req  (wr_req),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   // execute only once the previous response has gone
   assign finish    = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   // fetch the slot the request may need
   assign rd_en   = accept;
   assign rd_addr = (clib_pkg::op_type'(req_op) == clib_pkg::OP_TAKE) ?
                    rp_ff : clib_pkg::prev_pos(wp_ff);

   assign empty = (wp_ff == rp_ff);
   assign full  = (clib_pkg::next_pos(wp_ff) == rp_ff);

   assign put_char = (op_ff == clib_pkg::OP_KEY && ctrl_ff) ?
                     {3'b000, char_ff[4:0]} : char_ff;

   assign occupancy = (wp_ff >= rp_ff) ? (wp_ff - rp_ff) :
                      PW'(clib_pkg::DEPTH - 1) - (rp_ff - wp_ff) + PW'(1);

   always_comb begin
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      lc_in       = lc_ff;
      rsp_char_in = 8'h00;
      rsp_dlv_in  = 1'b0;
      rsp_stat_in = clib_pkg::STAT_OK;
      rsp_lend_in = 1'b0;
      do_put      = 1'b0;
      wr_req      = '0;

      case (op_ff)
         clib_pkg::OP_KEY: begin
            // keys above 127 are ignored
            if (char_ff <= clib_pkg::KEY_MAX) begin
               if (char_ff == clib_pkg::CH_BS && cooked_ff) begin
                  if (empty || rd_data == clib_pkg::CH_RET) begin
                     rsp_stat_in = clib_pkg::STAT_REFUSED;
                  end else begin
                     if (rd_data == clib_pkg::CH_NL && lc_ff != '0) begin
                        lc_in = lc_ff - PW'(1);
                     end
                     wp_in = clib_pkg::prev_pos(wp_ff);
                  end
               end else begin
                  do_put = 1'b1;
               end
            end
         end
         clib_pkg::OP_RAW: begin
            do_put = 1'b1;
         end
         clib_pkg::OP_TAKE: begin
            if (cooked_ff && lc_ff == '0) begin
               rsp_stat_in = clib_pkg::STAT_BLOCK;
            end else if (empty) begin
               rsp_stat_in = clib_pkg::STAT_EMPTY;
            end else begin
               rp_in = clib_pkg::next_pos(rp_ff);
               // bell is consumed silently
               if (rd_data != clib_pkg::CH_BEL) begin
                  rsp_dlv_in  = 1'b1;
                  rsp_char_in = rd_data;
                  if (rd_data == clib_pkg::CH_RET || rd_data == clib_pkg::CH_NL) begin
                     rsp_lend_in = 1'b1;
                     rsp_char_in = clib_pkg::CH_NL;
                     if (lc_ff != '0) begin
                        lc_in = lc_ff - PW'(1);
                     end
                  end
               end
            end
         end
         default: begin
         end
      endcase

      if (do_put) begin
         if (full) begin
            rsp_stat_in = clib_pkg::STAT_FULL;
         end else begin
            wr_req.en   = finish;
            wr_req.addr = wp_ff;
            wr_req.data = put_char;
            wp_in       = clib_pkg::next_pos(wp_ff);
            if (put_char == clib_pkg::CH_RET || put_char == clib_pkg::CH_NL) begin
               lc_in = lc_ff + PW'(1);
            end
         end
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (finish) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cooked_ff    <= 1'b1;
         wp_ff        <= '0;
         rp_ff        <= '0;
         lc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            cooked_ff <= csr_wr_data;
         end
         if (accept) begin
            op_ff   <= clib_pkg::op_type'(req_op);
            char_ff <= req_char_in;
            ctrl_ff <= req_ctrl_held;
         end
         if (finish) begin
            wp_ff        <= wp_in;
            rp_ff        <= rp_in;
            lc_ff        <= lc_in;
            rsp_valid_ff <= 1'b1;
            rsp_char_ff  <= rsp_char_in;
            rsp_dlv_ff   <= rsp_dlv_in;
            rsp_stat_ff  <= rsp_stat_in;
            rsp_lend_ff  <= rsp_lend_in;
            rsp_lines_ff <= clib_pkg::sat8(lc_in);
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_out      = rsp_char_ff;
   assign rsp_delivered     = rsp_dlv_ff;
   assign rsp_status        = 3'(rsp_stat_ff);
   assign rsp_line_end      = rsp_lend_ff;
   assign rsp_lines_pending = rsp_lines_ff;

   `AST_CHECK(a_lines_fit, clock, reset, lc_ff <= occupancy, "line count exceeds stored characters")
   `AST_CHECK(a_dlv_ok, clock, reset, rsp_valid_ff && rsp_dlv_ff |-> rsp_stat_ff == clib_pkg::STAT_OK, "delivered with error status")
   `AST_CHECK(a_lend_nl, clock, reset, rsp_valid_ff && rsp_lend_ff |-> rsp_dlv_ff && rsp_char_ff == clib_pkg::CH_NL, "line end not delivered as newline")
   `AST_ALWAYS(a_wr_exec, clock, wr_req.en |-> state_ff == ST_EXEC && !reset, "store written outside execute")

endmodule

/* design/clib_store.sv */
// Character store: one write port, one read port with registered read data.
module clib_store (
   input  logic                         clock,
   input  clib_pkg::wr_req_type         wr_req,
   input  logic                         rd_en,
   input  logic [clib_pkg::PTR_W-1:0]   rd_addr,
   output logic [7:0]                   rd_data
);

   logic [7:0] store_ff [clib_pkg::DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_req.en) begin
         store_ff[wr_req.addr] <= wr_req.data;
      end
   end

   // data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* verif/tb_top.sv */
// Self-checking testbench for the cooked line input buffer.
`timescale 1ns / 100ps

module tb_top;

   // Generous cycle budget: the slowest legal run is a few hundred requests,
   // each at most a sender gap, an idle-execute pass and a receiver stall.
   localparam int RUN_LIMIT = 200000;

   // How the receiver throttles rsp_ready.
   typedef enum int {
      DRAIN_FREE,
      DRAIN_RANDOM,
      DRAIN_PATTERN
   } drain_style_type;

   // One response as the line discipline should produce it.
   typedef struct {
      logic [7:0]           char_out;
      logic                 delivered;
      clib_pkg::status_type status;
      logic                 line_end;
      logic [7:0]           lines_pending;
   } buffer_outcome_type;

   logic       clock;
   logic       reset;
   logic       csr_wr_en;
   logic       csr_wr_data;
   logic       req_valid;
   logic       req_ready;
   logic [1:0] req_op;
   logic [7:0] req_char_in;
   logic       req_ctrl_held;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_char_out;
   logic       rsp_delivered;
   logic [2:0] rsp_status;
   logic       rsp_line_end;
   logic [7:0] rsp_lines_pending;

   // Shadow copy of the ring, its pointers, the line-end count and the mode.
   logic [7:0] shadow_ring [clib_pkg::DEPTH];
   int         ring_head;   // next slot to write
   int         ring_tail;   // next slot to take
   int         line_ends;
   logic       cooked;

   // Responses still owed by the block, oldest first.
   buffer_outcome_type buffer_outcomes [$];

   int              fault_count;
   int              requests_sent;
   int              burst_left;
   bit              sender_steady;
   drain_style_type stall_style;
   int              drain_tick;

   cooked_line_input_buffer i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_op            (req_op),
      .req_char_in       (req_char_in),
      .req_ctrl_held     (req_ctrl_held),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_char_out      (rsp_char_out),
      .rsp_delivered     (rsp_delivered),
      .rsp_status        (rsp_status),
      .rsp_line_end      (rsp_line_end),
      .rsp_lines_pending (rsp_lines_pending)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ---------------------------------------------------------------------
   // Line discipline predictor
   // ---------------------------------------------------------------------

   function automatic int ring_step(input int p);
      return (p + 1) % clib_pkg::DEPTH;
   endfunction

   // Store one character; the ring keeps one slot free, so full means the
   // next write slot is the take slot.
   function automatic clib_pkg::status_type ring_put(input logic [7:0] c);
      if (ring_step(ring_head) == ring_tail) return clib_pkg::STAT_FULL;
      if (c == clib_pkg::CH_RET || c == clib_pkg::CH_NL) line_ends++;
      shadow_ring[ring_head] = c;
      ring_head = ring_step(ring_head);
      return clib_pkg::STAT_OK;
   endfunction

   function automatic buffer_outcome_type line_discipline_step(input clib_pkg::op_type op,
                                                               input logic [7:0] ch,
                                                               input logic ctrl);
      buffer_outcome_type o;
      int                 top;
      logic [7:0]         c;
      o.char_out  = 8'd0;
      o.delivered = 1'b0;
      o.status    = clib_pkg::STAT_OK;
      o.line_end  = 1'b0;
      case (op)
         clib_pkg::OP_KEY: begin
            // Keys above the ASCII range are silently ignored.
            if (ch <= clib_pkg::KEY_MAX) begin
               // Erase is decided on the raw key, before ctrl masking.
               if (ch == clib_pkg::CH_BS && cooked) begin
                  if (ring_head == ring_tail) begin
                     o.status = clib_pkg::STAT_REFUSED;
                  end else begin
                     top = (ring_head + clib_pkg::DEPTH - 1) % clib_pkg::DEPTH;
                     // A completed return line can no longer be edited.
                     if (shadow_ring[top] == clib_pkg::CH_RET) begin
                        o.status = clib_pkg::STAT_REFUSED;
                     end else begin
                        if (shadow_ring[top] == clib_pkg::CH_NL && line_ends > 0)
                           line_ends--;
                        ring_head = top;
                     end
                  end
               end else begin
                  o.status = ring_put(ctrl ? (ch & 8'h1F) : ch);
               end
            end
         end
         clib_pkg::OP_RAW: begin
            o.status = ring_put(ch);
         end
         clib_pkg::OP_TAKE: begin
            if (cooked && line_ends == 0) begin
               o.status = clib_pkg::STAT_BLOCK;
            end else if (ring_head == ring_tail) begin
               o.status = clib_pkg::STAT_EMPTY;
            end else begin
               c = shadow_ring[ring_tail];
               ring_tail = ring_step(ring_tail);
               // Bell is consumed but never handed out.
               if (c != clib_pkg::CH_BEL) begin
                  o.delivered = 1'b1;
                  o.char_out  = c;
                  if (c == clib_pkg::CH_RET || c == clib_pkg::CH_NL) begin
                     o.line_end = 1'b1;
                     o.char_out = clib_pkg::CH_NL;
                     if (line_ends > 0) line_ends--;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      o.lines_pending = (line_ends > 255) ? 8'hFF : 8'(line_ends);
      return o;
   endfunction

   // ---------------------------------------------------------------------
   // Request side: back-to-back request bursts, with random gaps between them
   // unless sender_steady is set. Called and returns at a falling edge; valid
   // stays up within a burst, so it is never dropped and raised in the same step.
   // ---------------------------------------------------------------------

   task automatic send_request(input clib_pkg::op_type op, input logic [7:0] ch,
                               input logic ctrl);
      int gap;
      if (burst_left == 0) begin
         gap = sender_steady ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid = 1'b0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_op        = op;
      req_char_in   = ch;
      req_ctrl_held = ctrl;
      req_valid     = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      buffer_outcomes.push_back(line_discipline_step(op, ch, ctrl));
      requests_sent++;
      @(negedge clock);
   endtask

   // Stop sending and wait for every owed response, plus a short tail.
   task automatic settle_buffer();
      req_valid = 1'b0;
      while (buffer_outcomes.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Mode changes only once the block has gone quiet.
   task automatic set_cooked_mode(input logic mode);
      settle_buffer();
      csr_wr_en   = 1'b1;
      csr_wr_data = mode;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      cooked      = mode;
   endtask

   // ---------------------------------------------------------------------
   // Response side: throttling and checking
   // ---------------------------------------------------------------------

   always @(negedge clock) begin
      drain_tick++;
      case (stall_style)
         DRAIN_FREE:   rsp_ready = 1'b1;
         DRAIN_RANDOM: rsp_ready = ($urandom_range(0, 3) != 0);
         default:      rsp_ready = (drain_tick % 7) > 2;
      endcase
   end

   task automatic report_mismatch(input string what, input logic [7:0] want,
                                  input logic [7:0] got);
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
      fault_count++;
   endtask

   always @(posedge clock) begin : rsp_check
      buffer_outcome_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (buffer_outcomes.size() == 0) begin
            report_mismatch("unsolicited response", 8'd0, rsp_status);
         end else begin
            want = buffer_outcomes.pop_front();
            if (rsp_char_out !== want.char_out)
               report_mismatch("char_out", want.char_out, rsp_char_out);
            if (rsp_delivered !== want.delivered)
               report_mismatch("delivered", want.delivered, rsp_delivered);
            if (rsp_status !== want.status)
               report_mismatch("status", want.status, rsp_status);
            if (rsp_line_end !== want.line_end)
               report_mismatch("line_end", want.line_end, rsp_line_end);
            if (rsp_lines_pending !== want.lines_pending)
               report_mismatch("lines_pending", want.lines_pending, rsp_lines_pending);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Cooked-mode editing from reset: refusals, erase of a newline, ctrl
   // masking, out-of-range keys, bell swallowing and return delivered as NL.
   task automatic test_cooked_editing();
      int k;
      sender_steady = 1'b1;
      stall_style   = DRAIN_RANDOM;
      send_request(clib_pkg::OP_TAKE, 8'hFF, 1'b1);      // nothing pending: would block
      send_request(clib_pkg::OP_KEY, clib_pkg::CH_BS, 1'b0);  // erase on empty ring
      send_request(clib_pkg::OP_KEY, "a", 1'b1);         // ctrl-A
      send_request(clib_pkg::OP_KEY, 8'd200, 1'b0);      // above key range, ignored
      send_request(clib_pkg::OP_KEY, clib_pkg::KEY_MAX, 1'b0);
      send_request(clib_pkg::OP_KEY, clib_pkg::CH_BS, 1'b0);  // erases DEL
      send_request(clib_pkg::OP_KEY, "h", 1'b1);         // ctrl-H stored, not an erase
      send_request(clib_pkg::OP_KEY, "m", 1'b1);         // ctrl-M is a return
      send_request(clib_pkg::OP_KEY, clib_pkg::CH_BS, 1'b0);  // cannot erase past return
      send_request(clib_pkg::OP_RAW, clib_pkg::CH_NL, 1'b0);
      send_request(clib_pkg::OP_KEY, clib_pkg::CH_BS, 1'b0);  // newline can be erased
      send_request(clib_pkg::OP_RAW, clib_pkg::CH_BEL, 1'b0);
      send_request(clib_pkg::OP_KEY, clib_pkg::CH_NL, 1'b1);
      send_request(clib_pkg::OP_NONE, 8'hFF, 1'b1);
      for (k = 0; k < 5; k++) send_request(clib_pkg::OP_TAKE, 8'h00, 1'b0);
      send_request(clib_pkg::OP_TAKE, 8'h00, 1'b0);      // lines used up: would block
   endtask

   // Raw mode: backspace is just a character and takes never wait for a line.
   task automatic test_raw_mode();
      set_cooked_mode(1'b0);
      stall_style = DRAIN_FREE;
      send_request(clib_pkg::OP_TAKE, 8'h00, 1'b0);   // empty
      send_request(clib_pkg::OP_KEY, clib_pkg::CH_BS, 1'b0);
      send_request(clib_pkg::OP_KEY, "x", 1'b1);
      send_request(clib_pkg::OP_TAKE, 8'h55, 1'b1);
      send_request(clib_pkg::OP_TAKE, 8'hAA, 1'b0);
      send_request(clib_pkg::OP_TAKE, 8'h00, 1'b0);   // empty again
   endtask

   // Fill the ring until puts are dropped, poke at the full ring in cooked
   // mode, then take back part of it.
   task automatic test_fill_and_drain();
      int k;
      sender_steady = 1'b0;
      stall_style   = DRAIN_PATTERN;
      while (ring_step(ring_head) != ring_tail)
         send_request(clib_pkg::op_type'($urandom_range(0, 1)), 8'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)));
      for (k = 0; k < 3; k++)
         send_request(clib_pkg::op_type'($urandom_range(0, 1)), 8'($urandom_range(0, 127)),
                      1'($urandom_range(0, 1)));
      set_cooked_mode(1'b1);
      send_request(clib_pkg::OP_KEY, clib_pkg::CH_BS, 1'b0);
      send_request(clib_pkg::OP_KEY, "q", 1'b0);
      send_request(clib_pkg::OP_KEY, "q", 1'b0);
      set_cooked_mode(1'b0);
      for (k = 0; k < 64; k++)
         send_request(clib_pkg::OP_TAKE, 8'($urandom_range(0, 255)), 1'b0);
   endtask

   // Typed lines with occasional erases, ctrl keys and raw bytes, closed by
   // one of the line-end forms (or left open), then read back.
   task automatic test_line_editing();
      int first;
      int len;
      int takes;
      int k;
      set_cooked_mode(1'b1);
      sender_steady = 1'b0;
      stall_style   = DRAIN_RANDOM;
      first = requests_sent;
      while (requests_sent - first < 40) begin
         len = $urandom_range(1, 8);
         for (k = 0; k < len; k++) begin
            case ($urandom_range(0, 9))
               0:       send_request(clib_pkg::OP_KEY, clib_pkg::CH_BS, 1'b0);
               1:       send_request(clib_pkg::OP_RAW, 8'($urandom_range(0, 255)), 1'b0);
               2:       send_request(clib_pkg::OP_KEY, 8'($urandom_range(32, 126)), 1'b1);
               default: send_request(clib_pkg::OP_KEY, 8'($urandom_range(32, 126)), 1'b0);
            endcase
         end
         case ($urandom_range(0, 9))
            0:       ;   // line left unterminated
            1:       send_request(clib_pkg::OP_RAW, clib_pkg::CH_NL, 1'b0);
            2:       send_request(clib_pkg::OP_KEY, "m", 1'b1);
            3:       send_request(clib_pkg::OP_KEY, clib_pkg::CH_NL, 1'b0);
            default: send_request(clib_pkg::OP_KEY, clib_pkg::CH_RET, 1'b0);
         endcase
         // Take a little more than was typed so the ring trends empty.
         takes = len + $urandom_range(0, 3);
         for (k = 0; k < takes; k++)
            send_request(clib_pkg::OP_TAKE, 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
      end
   endtask

   // Unstructured requests of every opcode under each mode and pacing.
   task automatic test_random_mix();
      int phase;
      int k;
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               set_cooked_mode(1'b0);
               sender_steady = 1'b1;
               stall_style   = DRAIN_FREE;
            end
            1: begin
               set_cooked_mode(1'b1);
               sender_steady = 1'b0;
               stall_style   = DRAIN_PATTERN;
            end
            default: begin
               set_cooked_mode(1'($urandom_range(0, 1)));
               sender_steady = 1'b0;
               stall_style   = DRAIN_RANDOM;
            end
         endcase
         for (k = 0; k < 12; k++)
            send_request(clib_pkg::op_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)));
      end
   endtask

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------

   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = 1'b0;
      req_valid     = 1'b0;
      req_op        = clib_pkg::OP_NONE;
      req_char_in   = 8'h00;
      req_ctrl_held = 1'b0;
      rsp_ready     = 1'b0;
      ring_head     = 0;
      ring_tail     = 0;
      line_ends     = 0;
      cooked        = 1'b1;
      fault_count   = 0;
      requests_sent = 0;
      burst_left    = 0;
      drain_tick    = 0;
      sender_steady = 1'b1;
      stall_style   = DRAIN_FREE;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      test_cooked_editing();
      test_raw_mode();
      test_fill_and_drain();
      test_line_editing();
      test_random_mix();

      settle_buffer();
      repeat (8) @(negedge clock);
      if (fault_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin : watchdog
      int cycle_count;
      for (cycle_count = 0; cycle_count < RUN_LIMIT; cycle_count++) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

endmodule
